### src/tgarle_pkg.sv
`default_nettype none

package tgarle_pkg;

	localparam logic [24:0] MAX_PIXELS   = 25'd16777216;
	localparam logic [7:0]  RUN_BASE     = 8'd128;
	localparam logic [7:0]  RUN_BIAS     = 8'd127;
	localparam logic [2:0]  BPP_RESET    = 3'd4;
	localparam logic [24:0] PIXCNT_RESET = 25'd1;

	// Register index as decoded from the word address.
	typedef enum logic {
		REG_BYTES_PER_PIXEL = 1'b0,
		REG_PIXEL_COUNT     = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_TRUNC    = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic        in_packet;
		logic        is_run;
		logic [7:0]  pixels_left;
		logic [1:0]  byte_in_pixel;
		logic [31:0] pixel_asm;
		logic [24:0] pixels_done;
	} dec_state_t;

	typedef struct packed {
		logic        valid;
		logic [31:0] pixel_value;
		logic [23:0] start_index;
		logic [7:0]  repeat_res;
		status_t     status;
		logic        image_done;
	} dec_result_t;

endpackage

`default_nettype wire

### src/tgarle_step.sv
`default_nettype none

module tgarle_step (
	input  wire logic [2:0]           bytes_per_pixel,
	input  wire logic [24:0]          pixel_count,
	input  wire logic [7:0]           data_byte,
	input  wire logic                 stream_end,
	input  wire tgarle_pkg::dec_state_t  cur,
	output tgarle_pkg::dec_state_t       nxt,
	output tgarle_pkg::dec_result_t      res
);
	import tgarle_pkg::*;

	logic [2:0]  bpp_eff;
	logic [31:0] asm_new;
	logic [24:0] limit;
	logic [24:0] room;
	logic [7:0]  count;
	logic [24:0] done_new;
	logic [7:0]  left_new;

	always_comb begin
		unique case (bytes_per_pixel) inside
			3'd0: bpp_eff = 3'd1;
			[3'd1:3'd4]: bpp_eff = bytes_per_pixel;
			default: bpp_eff = 3'd4;
		endcase
	end

	assign asm_new  = cur.pixel_asm | ({24'b0, data_byte} << {cur.byte_in_pixel, 3'b000});
	assign limit    = (pixel_count > MAX_PIXELS) ? MAX_PIXELS : pixel_count;
	assign room     = (limit > cur.pixels_done) ? (limit - cur.pixels_done) : 25'd0;
	assign count    = cur.is_run ? cur.pixels_left : 8'd1;
	assign done_new = cur.pixels_done + {17'b0, count};
	assign left_new = cur.pixels_left - count;

	always_comb begin
		nxt = cur;
		res = '0;
		res.status = ST_OK;
		if (stream_end) begin
			res.valid       = 1'b1;
			res.start_index = cur.pixels_done[23:0];
			res.status      = ST_TRUNC;
			res.image_done  = 1'b1;
			nxt             = '0;
		end else if (!cur.in_packet) begin
			// Header byte: raw packets carry header+1 pixels, runs header-127 copies.
			nxt.in_packet     = 1'b1;
			nxt.byte_in_pixel = 2'd0;
			nxt.pixel_asm     = '0;
			if (data_byte < RUN_BASE) begin
				nxt.is_run      = 1'b0;
				nxt.pixels_left = data_byte + 8'd1;
			end else begin
				nxt.is_run      = 1'b1;
				nxt.pixels_left = data_byte - RUN_BIAS;
			end
		end else if (({1'b0, cur.byte_in_pixel} + 3'd1) < bpp_eff) begin
			nxt.byte_in_pixel = cur.byte_in_pixel + 2'd1;
			nxt.pixel_asm     = asm_new;
		end else if ({17'b0, count} > room) begin
			// Room is below count here, so it always fits in eight bits.
			res.valid       = 1'b1;
			res.pixel_value = asm_new;
			res.start_index = cur.pixels_done[23:0];
			res.repeat_res  = room[7:0];
			res.status      = ST_OVERFLOW;
			res.image_done  = 1'b1;
			nxt             = '0;
		end else begin
			res.valid         = 1'b1;
			res.pixel_value   = asm_new;
			res.start_index   = cur.pixels_done[23:0];
			res.repeat_res    = count;
			nxt.pixels_done   = done_new;
			nxt.pixels_left   = left_new;
			nxt.byte_in_pixel = 2'd0;
			nxt.pixel_asm     = '0;
			if (left_new == 8'd0) begin
				nxt.in_packet = 1'b0;
				nxt.is_run    = 1'b0;
				if (done_new >= limit) begin
					res.image_done = 1'b1;
					nxt            = '0;
				end
			end
		end
	end

endmodule

`default_nettype wire

### src/tga_rle_pixel_decoder.sv
// TGA run-length pixel decoder.
// The slave stream takes one compressed byte per word: s_axis_tdata is the data
// byte, and s_axis_tuser flags the end of the source (the byte is then ignored
// and a truncation result is produced). Header bytes and all but the last byte
// of a pixel produce no result word.
// The master stream gives one word per finished pixel: the pixel value, its
// start index and repeat count in tdata, the status code in tuser, and tlast
// on the word that completes or aborts the image.
// The result of a byte is registered: it sits in the output register on the
// cycle after that byte is accepted. One byte is accepted every cycle while the
// output is not stalled; the decoder state updates in a single pass of per-byte
// logic. When the receiver stalls with a word held, s_axis_tready drops and no
// byte is taken until the word leaves; the held word goes out the same cycle a
// new one is loaded.
// Reset clears the decoder state and loads bytes_per_pixel = 4 and
// pixel_count = 1. Registers sit at APB byte address 0 (bytes_per_pixel) and 4
// (pixel_count); the user must write them only with the stream idle (unenforced).
`default_nettype none

module tga_rle_pixel_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready,
	// Input stream
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  wire logic        s_axis_tuser,   // [0] stream_end
	// Output stream
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [63:0] m_axis_tdata,   // [31:0] pixel_value, [55:32] start_index,
	                                         // [63:56] repeat_res
	output      logic [1:0]  m_axis_tuser,   // [1:0] status
	output      logic        m_axis_tlast    // image_done
);
	import tgarle_pkg::*;

	logic [2:0]  bpp_q;
	logic [24:0] pixcnt_q;
	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_result_t res;
	logic        in_fire;
	logic        cfg_wr;
	reg_idx_t    reg_sel;

	logic [31:0] pixel_value_q;
	logic [23:0] start_index_q;
	logic [7:0]  repeat_res_q;
	status_t     status_q;
	logic        image_done_q;
	logic        out_valid_q;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_comb begin
		unique case (reg_sel)
			REG_BYTES_PER_PIXEL: prdata = {29'b0, bpp_q};
			REG_PIXEL_COUNT:     prdata = {7'b0, pixcnt_q};
			default:             prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q    <= BPP_RESET;
			pixcnt_q <= PIXCNT_RESET;
		end else if (cfg_wr) begin
			if (reg_sel == REG_BYTES_PER_PIXEL) begin
				bpp_q <= pwdata[2:0];
			end else begin
				pixcnt_q <= pwdata[24:0];
			end
		end
	end

	tgarle_step u_step (
		.bytes_per_pixel (bpp_q),
		.pixel_count     (pixcnt_q),
		.data_byte       (s_axis_tdata),
		.stream_end      (s_axis_tuser),
		.cur             (state_q),
		.nxt             (state_nxt),
		.res             (res)
	);

	// A byte may enter whenever the output register is empty or being drained.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				state_q <= state_nxt;
			end
			if (in_fire && res.valid) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && res.valid) begin
			pixel_value_q <= res.pixel_value;
			start_index_q <= res.start_index;
			repeat_res_q  <= res.repeat_res;
			status_q      <= res.status;
			image_done_q  <= res.image_done;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {repeat_res_q, start_index_q, pixel_value_q};
	assign m_axis_tuser  = status_q;
	assign m_axis_tlast  = image_done_q;

endmodule

`default_nettype wire
